// File: sv/pltc_pkg.sv
// Shared types and constants for the piecewise linear tone curve.
package pltc_pkg;

   localparam int NUM_POINTS   = 6;
   localparam int PIX_W        = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int COUNT_W      = 3;
   localparam int QUO_W        = 8;
   localparam int DIV_STAGES   = 4;
   localparam int DIV_BITS     = QUO_W / DIV_STAGES;
   localparam int DVD_W        = 17;
   localparam int DVS_W        = 9;
   localparam int PROD_W       = 18;

   localparam logic [COUNT_W-1:0] MAX_POINTS = COUNT_W'(NUM_POINTS);

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_5     = 3'd6;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic [PIX_W-1:0] level_out;
   } point_type;

endpackage

// File: sv/piecewise_linear_tone_curve.sv
// Top level: tone curve lookup, interpolation and pipelined rounding divider.
// One pixel is accepted every cycle while busy is low.
// Depth is set by segment select, setup, multiply, sum, then 4 divider stages
// of 2 quotient bits each. The receiver cannot stall; results are strobed.
// Reset (synchronous, active high) empties the pipe, holds busy high, and loads
// point_count = 2, point_1 = 0xFFFF, all other points 0.
module piecewise_linear_tone_curve (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pltc_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                             rsp_valid,
   output logic [pltc_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic                             csr_we,
   input  logic [pltc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pltc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pltc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   point_type          point_ff [NUM_POINTS];

   // stage 1: segment select
   logic               s1_vld_ff;
   logic [PIX_W-1:0]   s1_px_ff, s1_r1_ff, s1_s1_ff, s1_r2_ff, s1_s2_ff;
   logic [PIX_W-1:0]   s1_px_in, s1_r1_in, s1_s1_in, s1_r2_in, s1_s2_in;
   // stage 2: differences
   logic               s2_vld_ff;
   logic [PIX_W-1:0]   s2_den_ff, s2_d_ff, s2_s1_ff;
   logic signed [PIX_W:0] s2_diff_ff;
   // stage 3: products
   logic               s3_vld_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;
   logic [2*PIX_W-1:0] s3_s1den_ff;
   logic [PIX_W-1:0]   s3_den_ff;
   // divider
   logic               div_vld_ff [DIV_STAGES+1];
   logic [QUO_W-1:0]   div_q_ff   [DIV_STAGES+1];
   logic [DVD_W-1:0]   div_rem_ff [DIV_STAGES];
   logic [DVS_W-1:0]   div_dvs_ff [DIV_STAGES];
   logic [QUO_W-1:0]   div_q_in   [DIV_STAGES];
   logic [DVD_W-1:0]   div_rem_in [DIV_STAGES-1];
   logic signed [PROD_W-1:0] base_sum;
   logic [DVD_W-1:0]   dvd_in;

   logic               accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(2);
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= '0;
         end
         point_ff[1] <= '1;
      end else if (csr_we) begin
         if (csr_index == CSR_POINT_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end else if (csr_index inside {[CSR_POINT_0:CSR_POINT_5]}) begin
            point_ff[csr_index - CSR_POINT_0] <= csr_wdata;
         end
      end
   end

   // stage 1: first point at or above the pixel; non-interpolating cases are
   // folded into a flat segment (r1=0, r2=1, s1=s2=value) so all share one path
   always_comb begin
      logic [COUNT_W-1:0] n;
      logic               found;
      logic [COUNT_W-1:0] idx;
      logic [COUNT_W-1:0] lo_idx;
      logic [COUNT_W-1:0] last;
      logic [PIX_W-1:0]   flat;
      logic               interp;
      n      = (count_ff > MAX_POINTS) ? MAX_POINTS : count_ff;
      found  = 1'b0;
      idx    = '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
         if (!found && (COUNT_W'(i) < n) && (point_ff[i].level >= req_pixel_in)) begin
            found = 1'b1;
            idx   = COUNT_W'(i);
         end
      end
      lo_idx = idx - COUNT_W'(1);
      last   = n - COUNT_W'(1);
      interp = 1'b0;
      if (n == '0) begin
         flat = req_pixel_in;
      end else if (!found) begin
         flat = point_ff[last].level_out;
      end else if (idx == '0) begin
         flat = point_ff[0].level_out;
      end else begin
         flat   = '0;
         interp = 1'b1;
      end
      if (interp) begin
         s1_px_in = req_pixel_in;
         s1_r1_in = point_ff[lo_idx].level;
         s1_s1_in = point_ff[lo_idx].level_out;
         s1_r2_in = point_ff[idx].level;
         s1_s2_in = point_ff[idx].level_out;
      end else begin
         s1_px_in = '0;
         s1_r1_in = '0;
         s1_s1_in = flat;
         s1_r2_in = PIX_W'(1);
         s1_s2_in = flat;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff <= s1_px_in;
      s1_r1_ff <= s1_r1_in;
      s1_s1_ff <= s1_s1_in;
      s1_r2_ff <= s1_r2_in;
      s1_s2_ff <= s1_s2_in;
      s2_den_ff  <= s1_r2_ff - s1_r1_ff;
      s2_d_ff    <= s1_px_ff - s1_r1_ff;
      s2_s1_ff   <= s1_s1_ff;
      s2_diff_ff <= $signed({1'b0, s1_s2_ff}) - $signed({1'b0, s1_s1_ff});
      s3_prod_ff  <= PROD_W'($signed({1'b0, s2_d_ff}) * s2_diff_ff);
      s3_s1den_ff <= s2_s1_ff * s2_den_ff;
      s3_den_ff   <= s2_den_ff;
   end

   // stage 4: dividend 2*base + den, divisor 2*den
   assign base_sum = $signed({2'b00, s3_s1den_ff}) + s3_prod_ff;
   assign dvd_in   = {base_sum[2*PIX_W-1:0], 1'b0} + DVD_W'(s3_den_ff);

   always_ff @(posedge clock) begin
      div_rem_ff[0] <= dvd_in;
      div_dvs_ff[0] <= {s3_den_ff, 1'b0};
      div_q_ff[0]   <= '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         div_rem_ff[s] <= div_rem_in[s-1];
         div_dvs_ff[s] <= div_dvs_ff[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         div_q_ff[s+1] <= div_q_in[s];
      end
   end

   // restoring division, quotient known to fit QUO_W bits
   always_comb begin
      logic [DVD_W-1:0] rem;
      logic [QUO_W-1:0] q;
      logic [DVD_W-1:0] trial;
      int               k;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem = div_rem_ff[s];
         q   = div_q_ff[s];
         for (int b = 0; b < DIV_BITS; b++) begin
            k     = QUO_W - 1 - s * DIV_BITS - b;
            trial = DVD_W'(div_dvs_ff[s]) << k;
            if (rem >= trial) begin
               rem  = rem - trial;
               q[k] = 1'b1;
            end
         end
         div_q_in[s] = q;
         if (s < DIV_STAGES - 1) begin
            div_rem_in[s] = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         for (int s = 0; s <= DIV_STAGES; s++) begin
            div_vld_ff[s] <= 1'b0;
         end
      end else begin
         s1_vld_ff     <= accept;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         div_vld_ff[0] <= s3_vld_ff;
         for (int s = 0; s < DIV_STAGES; s++) begin
            div_vld_ff[s+1] <= div_vld_ff[s];
         end
      end
   end

   assign rsp_valid     = div_vld_ff[DIV_STAGES];
   assign rsp_pixel_out = div_q_ff[DIV_STAGES];

endmodule

// File: sv/pltc_checker.sv
// Port-level checker for the tone curve block, bound to the top level.
module pltc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [pltc_pkg::PIX_W-1:0]       rsp_pixel_out
);

   localparam int LATENCY = 8;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transfer accepted without result after fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching input transfer");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised out of reset");

   a_reset_flush: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_out_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_pixel_out))
      else $error("unknown pixel on a result transfer");

endmodule

bind piecewise_linear_tone_curve pltc_checker u_pltc_checker (.*);
